FILE: design/oaa_pkg.sv
// Shared constants for the oversampled converter averager.
// Configuration register indexes, reset values, field widths and default parameters.
// No dependencies.
`default_nettype none

package oaa_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXTRA_BITS = 2'd0,
        CFG_MV_GAIN    = 2'd1,
        CFG_MARGIN     = 2'd2
    } cfg_index_t;

    // register and field widths
    localparam int EB_W     = 3;
    localparam int GAIN_W   = 16;
    localparam int MARGIN_W = 16;
    localparam int WS_W     = 16;
    localparam int MV_W     = 15;
    localparam int MV_FRAC  = 16;

    localparam logic [EB_W-1:0]     EXTRA_BITS_RESET = 3'd5;
    localparam logic [GAIN_W-1:0]   GAIN_RESET       = 16'd29125;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET     = 16'd5;

    localparam longint WS_MAX = (64'd1 << WS_W) - 64'd1;
    localparam longint MV_MAX = (64'd1 << MV_W) - 64'd1;

    // default parameters
    localparam int TAPS_DEFAULT           = 5;
    localparam int MAX_EXTRA_BITS_DEFAULT = 5;
    localparam int SAMPLE_BITS_DEFAULT    = 8;

endpackage

`default_nettype wire

FILE: design/oversampled_adc_averager.sv
// Oversampled converter averager: top level with configuration registers.
// Depends on oaa_pkg, oaa_decimator, oaa_window and oaa_scale.
//
// Takes one converter sample per clock while the output is not stalled. Samples are
// summed in blocks of 4^extra_bits and each block gives one code (sum >> extra_bits).
// The first code seeds a TAPS-deep window and is not reported; each later code
// updates the window sum, and a transaction on the output is produced when that sum
// moves by more than change_margin from the last reported one. A result passes through
// one register each for the decimated code, the window report and the scaled output.
// Rate is set by the accumulator, the window update and the 16-bit gain multiply,
// each one stage deep.
// Backpressure on the output stalls all three stages. Configuration writes take
// effect on the next clock; the gain is not adjusted for extra_bits.
`default_nettype none

module oversampled_adc_averager #(
    parameter int TAPS           = oaa_pkg::TAPS_DEFAULT,
    parameter int MAX_EXTRA_BITS = oaa_pkg::MAX_EXTRA_BITS_DEFAULT,
    parameter int SAMPLE_BITS    = oaa_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [oaa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [oaa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [SAMPLE_BITS-1:0]         adc_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [oaa_pkg::WS_W-1:0]       window_sum,
    output logic [oaa_pkg::MV_W-1:0]       avg_millivolts
);
    import oaa_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + 2 * MAX_EXTRA_BITS;
    localparam int SUM_W = ACC_W + $clog2(TAPS);

    logic [EB_W-1:0]     extra_bits_reg;
    logic [GAIN_W-1:0]   mv_gain_reg;
    logic [MARGIN_W-1:0] margin_reg;

    logic             code_valid;
    logic             code_ready;
    logic [ACC_W-1:0] code;
    logic             rep_valid;
    logic             rep_ready;
    logic [SUM_W-1:0] rep_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_bits_reg <= EXTRA_BITS_RESET;
            mv_gain_reg    <= GAIN_RESET;
            margin_reg     <= MARGIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_EXTRA_BITS: extra_bits_reg <= cfg_data[EB_W-1:0];
                CFG_MV_GAIN:    mv_gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_MARGIN:     margin_reg     <= cfg_data[MARGIN_W-1:0];
                default:        ;
            endcase
        end
    end

    oaa_decimator #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_EXTRA_BITS (MAX_EXTRA_BITS),
        .ACC_W          (ACC_W)
    ) u_decimator (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .extra_bits (extra_bits_reg),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code       (code)
    );

    oaa_window #(
        .TAPS  (TAPS),
        .ACC_W (ACC_W),
        .SUM_W (SUM_W)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .code_valid    (code_valid),
        .code_ready    (code_ready),
        .code          (code),
        .change_margin (margin_reg),
        .rep_valid     (rep_valid),
        .rep_ready     (rep_ready),
        .rep_sum       (rep_sum)
    );

    oaa_scale #(
        .SUM_W (SUM_W)
    ) u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .rep_valid      (rep_valid),
        .rep_ready      (rep_ready),
        .rep_sum        (rep_sum),
        .mv_gain_q16    (mv_gain_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .window_sum     (window_sum),
        .avg_millivolts (avg_millivolts)
    );

endmodule

`default_nettype wire

FILE: design/oaa_decimator.sv
// Oversampling accumulator: sums 4^n samples and emits one code shifted right by n.
// Depends on oaa_pkg.
`default_nettype none

module oaa_decimator #(
    parameter int SAMPLE_BITS    = 8,
    parameter int MAX_EXTRA_BITS = 5,
    parameter int ACC_W          = SAMPLE_BITS + 2 * MAX_EXTRA_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [SAMPLE_BITS-1:0]     adc_sample,
    input  logic [oaa_pkg::EB_W-1:0]   extra_bits,
    output logic                       code_valid,
    input  logic                       code_ready,
    output logic [ACC_W-1:0]           code
);
    import oaa_pkg::*;

    localparam int CNT_W = 2 * MAX_EXTRA_BITS + 1;
    localparam logic [CNT_W-1:0] MAX_TARGET = CNT_W'(1) << (2 * MAX_EXTRA_BITS);

    logic [CNT_W-1:0] count_reg;
    logic [ACC_W-1:0] acc_reg;
    logic             code_vld_reg;
    logic [ACC_W-1:0] code_reg;

    logic [EB_W-1:0]  n_active;
    logic [CNT_W-1:0] target;
    logic [CNT_W-1:0] count_inc;
    logic [ACC_W-1:0] acc_sum;
    logic             block_done;
    logic             accept;
    logic             code_vld_next;

    always_comb
    begin
        if (32'(extra_bits) > 32'(MAX_EXTRA_BITS))
        begin
            n_active = EB_W'(MAX_EXTRA_BITS);
        end
        else
        begin
            n_active = extra_bits;
        end
    end

    assign target     = CNT_W'(1) << {n_active, 1'b0};
    assign count_inc  = count_reg + CNT_W'(1);
    assign acc_sum    = acc_reg + ACC_W'(adc_sample);
    // a shrunk target completes the block at once
    assign block_done = count_inc >= target;

    assign in_ready = !code_vld_reg || code_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        code_vld_next = code_vld_reg && !code_ready;
        if (accept && block_done)
        begin
            code_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            acc_reg      <= '0;
            code_vld_reg <= 1'b0;
        end
        else
        begin
            code_vld_reg <= code_vld_next;
            if (accept)
            begin
                if (block_done)
                begin
                    count_reg <= '0;
                    acc_reg   <= '0;
                end
                else
                begin
                    count_reg <= count_inc;
                    acc_reg   <= acc_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && block_done)
        begin
            code_reg <= acc_sum >> n_active;
        end
    end

    assign code_valid = code_vld_reg;
    assign code       = code_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < MAX_TARGET || (MAX_EXTRA_BITS == 0 && count_reg == '0))
        else $error("sample count beyond largest block");

endmodule

`default_nettype wire

FILE: design/oaa_window.sv
// Moving window over decimated codes with change-triggered reporting.
// Depends on oaa_pkg.
`default_nettype none

module oaa_window #(
    parameter int TAPS  = 5,
    parameter int ACC_W = 18,
    parameter int SUM_W = ACC_W + $clog2(TAPS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          code_valid,
    output logic                          code_ready,
    input  logic [ACC_W-1:0]              code,
    input  logic [oaa_pkg::MARGIN_W-1:0]  change_margin,
    output logic                          rep_valid,
    input  logic                          rep_ready,
    output logic [SUM_W-1:0]              rep_sum
);
    import oaa_pkg::*;

    localparam int PTR_W = $clog2(TAPS);
    localparam int CMP_W = (SUM_W > MARGIN_W) ? SUM_W : MARGIN_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TAPS - 1);

    logic [ACC_W-1:0] hist_reg [TAPS];
    logic [PTR_W-1:0] ptr_reg;
    logic [SUM_W-1:0] running_reg;
    logic [SUM_W-1:0] reported_reg;
    logic             seeded_reg;
    logic             rep_vld_reg;
    logic [SUM_W-1:0] rep_sum_reg;

    logic             accept;
    logic [SUM_W-1:0] running_upd;
    logic [SUM_W-1:0] seed_sum;
    logic [SUM_W-1:0] diff;
    logic             over_margin;
    logic             report;
    logic [PTR_W-1:0] ptr_inc;
    logic             rep_vld_next;

    assign code_ready = !rep_vld_reg || rep_ready;
    assign accept     = code_valid && code_ready;

    assign running_upd = running_reg - SUM_W'(hist_reg[ptr_reg]) + SUM_W'(code);
    assign seed_sum    = SUM_W'(code) * SUM_W'(TAPS);
    assign diff        = (running_upd >= reported_reg) ? running_upd - reported_reg
                                                       : reported_reg - running_upd;
    assign over_margin = CMP_W'(diff) > CMP_W'(change_margin);
    assign report      = accept && seeded_reg && over_margin;
    assign ptr_inc     = (ptr_reg == LAST_PTR) ? '0 : ptr_reg + PTR_W'(1);

    always_comb
    begin
        rep_vld_next = rep_vld_reg && !rep_ready;
        if (report)
        begin
            rep_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= '0;
            end
            ptr_reg      <= '0;
            running_reg  <= '0;
            reported_reg <= '0;
            seeded_reg   <= 1'b0;
            rep_vld_reg  <= 1'b0;
        end
        else
        begin
            rep_vld_reg <= rep_vld_next;
            if (accept)
            begin
                if (!seeded_reg)
                begin
                    // first code fills every slot
                    for (int i = 0; i < TAPS; i++)
                    begin
                        hist_reg[i] <= code;
                    end
                    running_reg  <= seed_sum;
                    reported_reg <= seed_sum;
                    ptr_reg      <= '0;
                    seeded_reg   <= 1'b1;
                end
                else
                begin
                    hist_reg[ptr_reg] <= code;
                    running_reg       <= running_upd;
                    ptr_reg           <= ptr_inc;
                    if (over_margin)
                    begin
                        reported_reg <= running_upd;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (report)
        begin
            rep_sum_reg <= running_upd;
        end
    end

    assign rep_valid = rep_vld_reg;
    assign rep_sum   = rep_sum_reg;

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ptr_reg) < TAPS)
        else $error("history pointer out of range");

    a_report_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        rep_vld_reg |-> seeded_reg)
        else $error("report before window was seeded");

    a_report_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        rep_vld_reg |-> reported_reg == rep_sum_reg)
        else $error("pending report differs from last reported sum");

endmodule

`default_nettype wire

FILE: design/oaa_scale.sv
// Output stage: Q16 millivolt scaling, saturation and the result register.
// Depends on oaa_pkg.
`default_nettype none

module oaa_scale #(
    parameter int SUM_W = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rep_valid,
    output logic                          rep_ready,
    input  logic [SUM_W-1:0]              rep_sum,
    input  logic [oaa_pkg::GAIN_W-1:0]    mv_gain_q16,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [oaa_pkg::WS_W-1:0]      window_sum,
    output logic [oaa_pkg::MV_W-1:0]      avg_millivolts
);
    import oaa_pkg::*;

    localparam int PROD_W = SUM_W + GAIN_W;

    logic              out_vld_reg;
    logic [WS_W-1:0]   ws_reg;
    logic [MV_W-1:0]   mv_reg;

    logic              accept;
    logic [PROD_W-1:0] product;
    logic [SUM_W-1:0]  mv_full;
    logic [WS_W-1:0]   ws_sat;
    logic [MV_W-1:0]   mv_sat;

    assign rep_ready = !out_vld_reg || out_ready;
    assign accept    = rep_valid && rep_ready;

    assign product = PROD_W'(rep_sum) * PROD_W'(mv_gain_q16);
    assign mv_full = product[PROD_W-1:MV_FRAC];

    assign ws_sat = (64'(rep_sum) > 64'(WS_MAX)) ? WS_W'(WS_MAX) : WS_W'(rep_sum);
    assign mv_sat = (64'(mv_full) > 64'(MV_MAX)) ? MV_W'(MV_MAX) : MV_W'(mv_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (rep_ready)
        begin
            out_vld_reg <= rep_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ws_reg <= ws_sat;
            mv_reg <= mv_sat;
        end
    end

    assign out_valid      = out_vld_reg;
    assign window_sum     = ws_reg;
    assign avg_millivolts = mv_reg;

endmodule

`default_nettype wire

FILE: bench/oversampled_adc_averager_tb.sv
// Self-checking bench for oversampled_adc_averager: directed script, then random phases.
// Results are predicted on the fly and compared in order with each output transaction.
// Depends on oaa_pkg and oversampled_adc_averager.
`timescale 1ns / 100ps

module oversampled_adc_averager_tb;

    import oaa_pkg::*;

    localparam int WINDOW_TAPS     = TAPS_DEFAULT;
    localparam int MAX_EB          = MAX_EXTRA_BITS_DEFAULT;
    localparam int SAMPLE_W        = SAMPLE_BITS_DEFAULT;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_SETTLE      = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_ITEMS    = 400;
    localparam int MAX_SHOWN       = 10;
    localparam int SCRIPT_ROWS     = 21;

    typedef struct packed {
        logic [WS_W-1:0] ws;
        logic [MV_W-1:0] mv;
    } reading_t;

    // how the last sample of a script row is checked
    typedef enum logic [1:0] {
        BY_MODEL,
        NONE_TYPED,
        RESULT_TYPED
    } row_check_t;

    typedef enum logic [1:0] {
        SHAPE_NOISE,
        SHAPE_STEADY,
        SHAPE_RAMP,
        SHAPE_RAILS
    } shape_t;

    typedef struct packed {
        logic [EB_W-1:0]     eb;
        logic [GAIN_W-1:0]   gain;
        logic [MARGIN_W-1:0] margin;
        logic [SAMPLE_W-1:0] level;
        int                  run;
        row_check_t          check;
        logic [WS_W-1:0]     ws;
        logic [MV_W-1:0]     mv;
    } stim_row_t;

    // Each row: a run of identical samples under one register setting.
    localparam stim_row_t SCRIPT [SCRIPT_ROWS] = '{
        // reset settings, block left open; extra_bits above limit still needs 1024 samples
        '{3'd5, 16'd29125, 16'd5,     8'd255, 6,    BY_MODEL,     16'd0,     15'd0},
        '{3'd7, 16'd29125, 16'd5,     8'd255, 6,    NONE_TYPED,   16'd0,     15'd0},
        // extra_bits lowered with the count past the new target closes the block (seed)
        '{3'd3, 16'd29125, 16'd5,     8'd200, 51,   BY_MODEL,     16'd0,     15'd0},
        '{3'd0, 16'd29125, 16'd5,     8'd200, 1,    NONE_TYPED,   16'd0,     15'd0},
        // larger code reports with the window already above 16 bits, both outputs saturate
        '{3'd3, 16'd65535, 16'd5,     8'd255, 63,   BY_MODEL,     16'd0,     15'd0},
        '{3'd0, 16'd65535, 16'd5,     8'd255, 1,    RESULT_TYPED, 16'd65535, 15'd32767},
        '{3'd0, 16'd65535, 16'd5,     8'd0,   4,    BY_MODEL,     16'd0,     15'd0},
        '{3'd0, 16'd65535, 16'd5,     8'd0,   1,    RESULT_TYPED, 16'd0,     15'd0},
        // zero gain, zero margin
        '{3'd0, 16'd0,     16'd0,     8'd1,   1,    RESULT_TYPED, 16'd1,     15'd0},
        '{3'd0, 16'd0,     16'd0,     8'd1,   4,    BY_MODEL,     16'd0,     15'd0},
        // change equal to margin is quiet, one more reports
        '{3'd0, 16'd65535, 16'd2,     8'd3,   1,    NONE_TYPED,   16'd0,     15'd0},
        '{3'd0, 16'd65535, 16'd2,     8'd4,   1,    RESULT_TYPED, 16'd10,    15'd9},
        '{3'd0, 16'd29125, 16'd65535, 8'd255, 10,   NONE_TYPED,   16'd0,     15'd0},
        '{3'd1, 16'd29125, 16'd5,     8'd200, 8,    BY_MODEL,     16'd0,     15'd0},
        '{3'd2, 16'd29125, 16'd5,     8'd128, 32,   BY_MODEL,     16'd0,     15'd0},
        // extra_bits lowered mid-block: count already past the new target
        '{3'd5, 16'd29125, 16'd5,     8'd77,  10,   BY_MODEL,     16'd0,     15'd0},
        '{3'd0, 16'd29125, 16'd5,     8'd77,  1,    BY_MODEL,     16'd0,     15'd0},
        // extra_bits raised mid-block
        '{3'd1, 16'd29125, 16'd5,     8'd9,   2,    BY_MODEL,     16'd0,     15'd0},
        '{3'd3, 16'd29125, 16'd5,     8'd9,   62,   BY_MODEL,     16'd0,     15'd0},
        '{3'd2, 16'd65535, 16'd5,     8'd255, 16,   BY_MODEL,     16'd0,     15'd0},
        '{3'd0, 16'd65535, 16'd0,     8'd128, 5,    BY_MODEL,     16'd0,     15'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   adc_sample;
    logic                  out_valid;
    logic                  out_ready;
    logic [WS_W-1:0]       window_sum;
    logic [MV_W-1:0]       avg_millivolts;

    // predictor state and register copies
    logic [EB_W-1:0]     cfg_extra  = EXTRA_BITS_RESET;
    logic [GAIN_W-1:0]   cfg_gain   = GAIN_RESET;
    logic [MARGIN_W-1:0] cfg_margin = MARGIN_RESET;
    logic [10:0]         blk_count  = '0;
    logic [17:0]         blk_acc    = '0;
    logic [17:0]         code_ring [WINDOW_TAPS];
    int                  ring_pos   = 0;
    logic [20:0]         window_total  = '0;
    logic [20:0]         last_reported = '0;
    bit                  primed     = 1'b0;

    reading_t pending_readings [$];
    int       mismatches   = 0;
    int       idle_cycles  = 0;
    bit       tx_calm      = 1'b0;
    bit       hold_request = 1'b0;

    oversampled_adc_averager dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .adc_sample     (adc_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .window_sum     (window_sum),
        .avg_millivolts (avg_millivolts)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int idle_span(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Decimate, update the window and decide on a report for one sample.
    function automatic bit average_sample(input logic [SAMPLE_W-1:0] s, output reading_t r);
        logic [EB_W-1:0] nb;
        logic [10:0]     blk_len;
        logic [17:0]     code;
        logic [20:0]     diff;
        logic [36:0]     prod;
        logic [36:0]     mv_full;
        r = '0;
        nb = (cfg_extra > MAX_EB) ? EB_W'(MAX_EB) : cfg_extra;
        blk_len = 11'd1 << (2 * nb);
        blk_acc = blk_acc + s;
        blk_count = blk_count + 1'b1;
        if (blk_count < blk_len)
            return 1'b0;
        code = blk_acc >> nb;
        blk_acc = '0;
        blk_count = '0;
        if (!primed)
        begin
            for (int i = 0; i < WINDOW_TAPS; i++)
                code_ring[i] = code;
            window_total = 21'(code * WINDOW_TAPS);
            last_reported = window_total;
            ring_pos = 0;
            primed = 1'b1;
            return 1'b0;
        end
        window_total = window_total - code_ring[ring_pos] + code;
        code_ring[ring_pos] = code;
        ring_pos = (ring_pos == WINDOW_TAPS - 1) ? 0 : ring_pos + 1;
        diff = (window_total >= last_reported) ? window_total - last_reported
                                                : last_reported - window_total;
        if (diff <= cfg_margin)
            return 1'b0;
        last_reported = window_total;
        r.ws = (window_total > WS_MAX) ? '1 : window_total[WS_W-1:0];
        prod = window_total * cfg_gain;
        mv_full = prod >> MV_FRAC;
        r.mv = (mv_full > MV_MAX) ? '1 : mv_full[MV_W-1:0];
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] shape_sample(input shape_t shape, input int base,
                                                         input int spread, input int idx);
        int v;
        case (shape)
            SHAPE_NOISE:  v = $urandom_range(0, 255);
            SHAPE_STEADY: v = base + int'($urandom_range(0, 2 * spread)) - spread;
            SHAPE_RAMP:   v = (base + idx * spread) % 256;
            default:      v = $urandom_range(0, 1) ? 255 : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[SAMPLE_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic push_sample(input logic [SAMPLE_W-1:0] s, output bit got, output reading_t r);
        int gap;
        gap = idle_span(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = average_sample(s, r);
        @(negedge clk);
    endtask

    // Registers change only with no expected result pending and the pipeline settled.
    task automatic set_config(input logic [EB_W-1:0] eb, input logic [GAIN_W-1:0] gain,
                              input logic [MARGIN_W-1:0] margin);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_EXTRA_BITS;
        cfg_data  <= CFG_DATA_W'(eb);
        @(negedge clk);
        cfg_index <= CFG_MV_GAIN;
        cfg_data  <= gain;
        @(negedge clk);
        cfg_index <= CFG_MARGIN;
        cfg_data  <= margin;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        cfg_extra  = eb;
        cfg_gain   = gain;
        cfg_margin = margin;
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    initial
    begin : stimulus
        stim_row_t        row;
        reading_t         r;
        bit               got;
        int               fed;
        int               phase;
        int               codes;
        int               samples;
        int               base;
        int               spread;
        int               pick;
        shape_t           shape;
        logic [EB_W-1:0]     eb;
        logic [GAIN_W-1:0]   gain;
        logic [MARGIN_W-1:0] margin;

        in_valid   = 1'b0;
        adc_sample = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_EXTRA_BITS;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < SCRIPT_ROWS; k++)
        begin
            row = SCRIPT[k];
            if (row.eb != cfg_extra || row.gain != cfg_gain || row.margin != cfg_margin)
                set_config(row.eb, row.gain, row.margin);
            tx_calm = ($urandom_range(0, 2) == 0);
            for (int j = 0; j < row.run; j++)
            begin
                push_sample(row.level, got, r);
                if (j == row.run - 1 && row.check != BY_MODEL)
                begin
                    got  = (row.check == RESULT_TYPED);
                    r.ws = row.ws;
                    r.mv = row.mv;
                end
                if (got)
                    pending_readings.push_back(r);
            end
        end

        fed = 0;
        phase = 0;
        while (fed < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            eb = (pick < 4) ? 3'd0 : (pick < 7) ? 3'd1 : (pick < 9) ? 3'd2 : 3'd3;
            pick = $urandom_range(0, 99);
            gain = (pick < 10) ? 16'd0 : (pick < 20) ? 16'hFFFF : GAIN_W'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            margin = (pick < 15) ? 16'd0 :
                     (pick < 70) ? MARGIN_W'($urandom_range(0, 12)) :
                     (pick < 95) ? MARGIN_W'($urandom_range(0, 300)) : 16'hFFFF;
            shape = shape_t'($urandom_range(0, 3));
            tx_calm = ($urandom_range(0, 3) == 0);
            case (eb)
                3'd0:    codes = $urandom_range(20, 60);
                3'd1:    codes = $urandom_range(5, 15);
                3'd2:    codes = $urandom_range(2, 4);
                default: codes = $urandom_range(1, 2);
            endcase
            // one phase runs with the output held off so the pipeline backs up
            if (phase == 2)
            begin
                eb = 3'd0;
                margin = '0;
                shape = SHAPE_NOISE;
                tx_calm = 1'b1;
                codes = 60;
            end
            set_config(eb, gain, margin);
            if (phase == 2)
                hold_request = 1'b1;
            base = $urandom_range(0, 255);
            spread = (shape == SHAPE_RAMP) ? $urandom_range(1, 9) : $urandom_range(0, 3);
            samples = codes << (2 * eb);
            for (int j = 0; j < samples; j++)
            begin
                push_sample(shape_sample(shape, base, spread, j), got, r);
                if (got)
                    pending_readings.push_back(r);
                fed++;
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (END_SETTLE) @(negedge clk);
        if (mismatches == 0)
            $display("oversampled_adc_averager test passed");
        else
            $display("oversampled_adc_averager test failed");
        $finish;
    end

    initial
    begin : result_sink
        int stall_left;
        int mode_left;
        bit calm;
        stall_left = 0;
        mode_left = 0;
        calm = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    calm = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                if (stall_left > 0)
                    stall_left--;
                else
                    stall_left = idle_span(calm);
                out_ready <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
                note_mismatch("unexpected transaction, window_sum", -1, window_sum);
            else
            begin
                want = pending_readings.pop_front();
                if (window_sum !== want.ws)
                    note_mismatch("window_sum", want.ws, window_sum);
                if (avg_millivolts !== want.mv)
                    note_mismatch("avg_millivolts", want.mv, avg_millivolts);
            end
        end
    end

    // Ends a hung run: too many cycles with no transaction on either side.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("oversampled_adc_averager test failed");
            $finish;
        end
    end

endmodule
